### rtl/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants of the CSV field tokenizer
// Result item layout, byte codes and the push bundle between step and queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cft_pkg;

  localparam int MaxFieldsDefault = 256;

  localparam logic [7:0] QuoteByte   = 8'h22;
  localparam logic [7:0] NewlineByte = 8'h0A;
  localparam logic [7:0] DelimReset  = 8'd44;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] fbyte;
    logic [7:0] fnum;
    logic       rec;
    logic       hdr;
    logic       last;
  } cft_res_t;

  // Results caused by one accepted request: cnt is 0, 1 or 2, r0 goes out first.
  typedef struct packed {
    logic [1:0] cnt;
    cft_res_t   r0;
    cft_res_t   r1;
  } cft_push_t;

endpackage

`default_nettype wire

### rtl/cft_step.sv
// ----------------------------------------------------------------------------
// cft_step: tokenizer state and per-byte update
// Holds the delimiter register and parser state, and works out the results
// of the byte at the input in the same cycle it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_step import cft_pkg::*; #(
  parameter int MAX_FIELDS = MaxFieldsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_delimiter_char,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output cft_push_t       push
);

  localparam int FieldCapInt = (MAX_FIELDS - 1 < 255) ? (MAX_FIELDS - 1) : 255;
  localparam logic [7:0] FieldCap = 8'(FieldCapInt);

  typedef enum logic [1:0] {
    QM_OUT,
    QM_IN,
    QM_PEND
  } qmode_t;

  logic [7:0] delim_r;
  qmode_t     qm_r, qm_nxt;
  logic       has_r, has_nxt;
  logic       first_r, first_nxt;
  logic [7:0] fc_r, fc_nxt;

  qmode_t     qm_eff;
  logic       emit_a;
  cft_res_t   res_a;
  cft_res_t   res_end;

  always_comb begin
    qm_nxt    = qm_r;
    has_nxt   = has_r;
    first_nxt = first_r;
    fc_nxt    = fc_r;
    qm_eff    = qm_r;
    emit_a    = 1'b0;
    res_a     = '{kind: KindData, fbyte: text_byte, fnum: fc_r, rec: 1'b0,
                  hdr: first_r, last: 1'b0};
    res_end   = '{kind: KindEnd, fbyte: 8'd0, fnum: fc_r, rec: 1'b1,
                  hdr: first_r, last: 1'b1};
    push      = '0;

    if (text_byte == NewlineByte) begin
      // A newline ends the line, even inside quotes.
      push.cnt  = (first_r || has_r) ? 2'd1 : 2'd0;
      push.r0   = res_end;
      fc_nxt    = 8'd0;
      has_nxt   = 1'b0;
      first_nxt = 1'b0;
      qm_nxt    = QM_OUT;
    end else begin
      has_nxt = 1'b1;
      if (qm_r == QM_PEND) begin
        if (text_byte == QuoteByte) begin
          emit_a      = 1'b1;
          res_a.fbyte = QuoteByte;
          qm_nxt      = QM_IN;
        end else begin
          qm_eff = QM_OUT;
          qm_nxt = QM_OUT;
        end
      end
      if (!emit_a) begin
        if (qm_eff == QM_OUT) begin
          if (text_byte == delim_r) begin
            emit_a      = 1'b1;
            res_a.kind  = KindEnd;
            res_a.fbyte = 8'd0;
            if (fc_r < FieldCap) begin
              fc_nxt = fc_r + 8'd1;
            end
          end else if (text_byte == QuoteByte) begin
            qm_nxt = QM_IN;
          end else begin
            emit_a = 1'b1;
          end
        end else if (text_byte == QuoteByte) begin
          qm_nxt = QM_PEND;
        end else begin
          emit_a = 1'b1;
        end
      end

      // At end of text the line closes after the byte; it always holds bytes here.
      res_end.fnum = fc_nxt;
      if (end_of_text) begin
        if (emit_a) begin
          push.cnt = 2'd2;
          push.r0  = res_a;
          push.r1  = res_end;
        end else begin
          push.cnt = 2'd1;
          push.r0  = res_end;
        end
      end else begin
        res_a.last = 1'b1;
        push.cnt   = emit_a ? 2'd1 : 2'd0;
        push.r0    = res_a;
      end
    end

    if (end_of_text) begin
      qm_nxt    = QM_OUT;
      has_nxt   = 1'b0;
      first_nxt = 1'b1;
      fc_nxt    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DelimReset;
      qm_r    <= QM_OUT;
      has_r   <= 1'b0;
      first_r <= 1'b1;
      fc_r    <= 8'd0;
    end else begin
      if (cfg_we) begin
        delim_r <= cfg_delimiter_char;
      end
      if (accept) begin
        qm_r    <= qm_nxt;
        has_r   <= has_nxt;
        first_r <= first_nxt;
        fc_r    <= fc_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cft_resq.sv
// ----------------------------------------------------------------------------
// cft_resq: three-entry result queue
// Takes zero, one or two results per request, hands one out per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_resq import cft_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic accept,
  input  cft_push_t push,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output cft_res_t  head
);

  cft_res_t   mem_r [3];
  logic [1:0] rd_r, rd_nxt;
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] npush;
  logic [1:0] wr_p1;
  logic       pop;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  // Room for the worst case of two results keeps in_ready off the output path.
  assign room      = (cnt_r <= 2'd1);
  assign out_valid = (cnt_r != 2'd0);
  assign head      = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign npush     = accept ? push.cnt : 2'd0;
  assign wr_p1     = inc3(wr_r);

  always_comb begin
    rd_nxt  = pop ? inc3(rd_r) : rd_r;
    wr_nxt  = (npush == 2'd2) ? inc3(wr_p1) : ((npush == 2'd1) ? wr_p1 : wr_r);
    cnt_nxt = cnt_r + npush - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 2'd0;
      wr_r  <= 2'd0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (npush == 2'd2) begin
      mem_r[wr_p1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

### rtl/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer: streaming CSV field splitter
// Splits a byte stream into lines and quoted or plain fields.
//
//   Channel  Handshake             Carries
//   in_      in_valid / in_ready   text byte, end-of-text flag
//   out_     out_valid / out_ready field byte or field end, tags, run_last
//   cfg_     cfg_we                delimiter byte
//
// A byte is parsed in the cycle it is accepted and its results land in a
// three-entry queue, its first result visible the next cycle if it was empty.
// One request per cycle is taken while out_ready is high and each yields at
// most one result; a byte that yields two stalls input for the single port.
// in_ready is high while the queue holds at most one result.
// Reset is synchronous and active low; the delimiter returns to a comma.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer import cft_pkg::*; #(
  parameter int MAX_FIELDS = MaxFieldsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_delimiter_char,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_kind,
  output logic [7:0]      out_field_byte,
  output logic [7:0]      out_field_number,
  output logic            out_record_done,
  output logic            out_header_row,
  output logic            out_run_last
);

  logic      accept;
  logic      room;
  cft_push_t push;
  cft_res_t  head;

  assign in_ready = room;
  assign accept   = in_valid && room;

  cft_step #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_step (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_delimiter_char(cfg_delimiter_char),
    .accept            (accept),
    .text_byte         (in_text_byte),
    .end_of_text       (in_end_of_text),
    .push              (push)
  );

  cft_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_kind         = head.kind;
  assign out_field_byte   = head.fbyte;
  assign out_field_number = head.fnum;
  assign out_record_done  = head.rec;
  assign out_header_row   = head.hdr;
  assign out_run_last     = head.last;

endmodule

`default_nettype wire
